@@ rtl/cewi_pkg.sv @@
package cewi_pkg;

    localparam int CPU_IDX_W  = 6;
    localparam int KIND_W     = 2;
    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 16;
    localparam int OFFL_W     = 7;
    localparam int SUM_W      = 20;
    localparam int OUTC_W     = 3;

    localparam int CC_W       = 7;
    localparam int THR_W      = 14;
    localparam int LIM_W      = 6;
    localparam int WIN_W      = 22;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;

    localparam logic [SUM_W-1:0] SUM_MAX       = '1;
    localparam logic [THR_W-1:0] THRESHOLD_CAP = 14'd10000;
    localparam logic [WIN_W-1:0] WINDOW_CAP    = 22'd2592000;

    localparam logic [CC_W-1:0]  CC_RESET  = 7'd64;
    localparam logic [THR_W-1:0] THR_RESET = 14'd18;
    localparam logic [WIN_W-1:0] WIN_RESET = 22'd86400;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CPU_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 3'd4;

    localparam logic [OUTC_W-1:0] OUT_NONE       = 3'd0;
    localparam logic [OUTC_W-1:0] OUT_REQUEST    = 3'd1;
    localparam logic [OUTC_W-1:0] OUT_NOT_ONLINE = 3'd2;
    localparam logic [OUTC_W-1:0] OUT_BAD_CPU    = 3'd3;
    localparam logic [OUTC_W-1:0] OUT_LIMIT      = 3'd4;
    localparam logic [OUTC_W-1:0] OUT_DISABLED   = 3'd5;
    localparam logic [OUTC_W-1:0] OUT_CLEARED    = 3'd6;

    localparam logic [KIND_W-1:0] KIND_CE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UE = 2'd1;

    localparam logic ACT_EVENT  = 1'b0;
    localparam logic ACT_REPORT = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0]  ts;
        logic [COUNT_W-1:0] cnt;
    } ring_entry_t;

    typedef struct packed {
        logic               sub;
        logic [COUNT_W-1:0] operand;
    } sum_op_t;

endpackage

@@ rtl/cewi_ring_mem.sv @@
module cewi_ring_mem
    import cewi_pkg::*;
#(
    parameter int ADDR_W = 10
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  ring_entry_t       wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output ring_entry_t       rd_data
);

    ring_entry_t mem [2**ADDR_W];
    ring_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/cewi_cpu_table.sv @@
module cewi_cpu_table
    import cewi_pkg::*;
#(
    parameter int CPU_AW = 6,
    parameter int HEAD_W = 4,
    parameter int FILL_W = 5
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [CPU_AW-1:0] rd_addr,
    input  logic              wr_en,
    input  logic [CPU_AW-1:0] wr_addr,
    input  logic [HEAD_W-1:0] wr_head,
    input  logic [FILL_W-1:0] wr_fill,
    input  logic [SUM_W-1:0]  wr_sum,
    input  logic              wr_uflag,
    input  logic              clr_en,
    input  logic [CPU_AW-1:0] clr_addr,
    output logic [HEAD_W-1:0] rd_head,
    output logic [FILL_W-1:0] rd_fill,
    output logic [SUM_W-1:0]  rd_sum,
    output logic              rd_uflag
);

    localparam int REC_W   = 1 + SUM_W + FILL_W + HEAD_W;
    localparam int ENTRIES = 2**CPU_AW;

    logic [REC_W-1:0] rec_mem [ENTRIES];
    logic [REC_W-1:0] rd_rec_reg;
    logic             rd_vld_reg;
    logic             vld_reg [ENTRIES];
    logic [REC_W-1:0] rec_seen;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            rec_mem[wr_addr] <= {wr_uflag, wr_sum, wr_fill, wr_head};
        end
        if (rd_en) begin
            rd_rec_reg <= rec_mem[rd_addr];
        end
    end

    // A CPU whose entry was never written, or was cleared, reads as an empty record.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++) begin
                vld_reg[i] <= 1'b0;
            end
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (clr_en) begin
                vld_reg[clr_addr] <= 1'b0;
            end
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rec_seen = rd_vld_reg ? rd_rec_reg : '0;
    assign rd_head  = rec_seen[HEAD_W-1:0];
    assign rd_fill  = rec_seen[HEAD_W +: FILL_W];
    assign rd_sum   = rec_seen[HEAD_W + FILL_W +: SUM_W];
    assign rd_uflag = rec_seen[REC_W-1];

endmodule

@@ rtl/cewi_sum_unit.sv @@
module cewi_sum_unit
    import cewi_pkg::*;
(
    input  logic [SUM_W-1:0] sum_in,
    input  sum_op_t          op,
    output logic [SUM_W-1:0] sum_out
);

    logic [SUM_W:0]   add_full;
    logic [SUM_W-1:0] operand_w;

    always_comb begin
        operand_w = SUM_W'(op.operand);
        add_full  = {1'b0, sum_in} + {1'b0, operand_w};
        if (op.sub) begin
            sum_out = (sum_in > operand_w) ? (sum_in - operand_w) : '0;
        end else begin
            sum_out = add_full[SUM_W] ? SUM_MAX : add_full[SUM_W-1:0];
        end
    end

endmodule

@@ rtl/cpu_error_window_isolator.sv @@
// Channel   Direction  Signals                              Contents
// s_        in         s_tvalid s_tready s_tdata s_tuser    error event or offline outcome
// m_        out        m_tvalid m_tready m_tdata m_tuser    outcome, cpu, window sum
// cfg_      in         cfg_valid cfg_ready cfg_index cfg_data  register writes
//
// A request that stops short of the window check goes from ST_LOAD straight to ST_DONE.
// A corrected event that reaches the window check passes ST_HEAD (preceded by ST_TAIL
// when it lands in a full ring) and ST_CHECK, which reads each evicted ring entry through
// the single ring read port; s_tready returns as the result is loaded.
// aresetn is synchronous; it resets the sequencer and the configuration and
// clears the per-CPU valid bits, so every CPU starts with an empty record.
// A stalled result is held in the output register; one further item may be
// accepted and waits at its end until that register is free.
module cpu_error_window_isolator
    import cewi_pkg::*;
#(
    parameter int NUM_CPUS   = 64,
    parameter int RING_DEPTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // cpu_index[5:0], event_time[37:6], error_count[53:38], online[54],
    // cpus_offline[61:55], offline_ok[62], zero[63]
    input  logic [63:0]           s_tdata,
    // action[0], error_kind[2:1]
    input  logic [2:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // cpu_echo[5:0], window_errors[25:6], zero[31:26]
    output logic [31:0]           m_tdata,
    // outcome[2:0]
    output logic [OUTC_W-1:0]     m_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CPU_AW  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int HEAD_W  = $clog2(RING_DEPTH);
    localparam int FILL_W  = $clog2(RING_DEPTH + 1);
    localparam int WRAP_W  = HEAD_W + 1;
    localparam int RING_AW = CPU_AW + HEAD_W;

    localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(RING_DEPTH);
    localparam logic [WRAP_W-1:0] DEPTH_W = WRAP_W'(RING_DEPTH);
    localparam logic [8:0]        NCPU_9  = 9'(NUM_CPUS);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_TAIL  = 3'd2;
    localparam logic [2:0] ST_HEAD  = 3'd3;
    localparam logic [2:0] ST_CHECK = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    function automatic logic [HEAD_W-1:0] wrap_slot(input logic [WRAP_W-1:0] x);
        logic [WRAP_W-1:0] y;
        y = (x >= DEPTH_W) ? (x - DEPTH_W) : x;
        return y[HEAD_W-1:0];
    endfunction

    // Configuration.
    logic             en_reg;
    logic [CC_W-1:0]  cc_reg;
    logic [THR_W-1:0] thr_reg;
    logic [LIM_W-1:0] lim_reg;
    logic [WIN_W-1:0] win_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg  <= 1'b0;
            cc_reg  <= CC_RESET;
            thr_reg <= THR_RESET;
            lim_reg <= '0;
            win_reg <= WIN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_ENABLE:    en_reg  <= cfg_data[0];
                CFG_CPU_COUNT: cc_reg  <= cfg_data[CC_W-1:0];
                CFG_THRESHOLD: thr_reg <= cfg_data[THR_W-1:0];
                CFG_OFF_LIMIT: lim_reg <= cfg_data[LIM_W-1:0];
                CFG_WINDOW:    win_reg <= cfg_data[WIN_W-1:0];
                default:       ;
            endcase
        end
    end

    logic [THR_W-1:0] thr_cap;
    logic [WIN_W-1:0] win_cap;
    logic [CC_W-1:0]  cc_m1;
    logic [CC_W-1:0]  lim_eff;

    // A cpu_count of zero wraps cc_m1 to its top, which leaves the limit uncapped.
    assign thr_cap = (thr_reg > THRESHOLD_CAP) ? THRESHOLD_CAP : thr_reg;
    assign win_cap = (win_reg > WINDOW_CAP) ? WINDOW_CAP : win_reg;
    assign cc_m1   = cc_reg - 1'b1;
    assign lim_eff = ({1'b0, lim_reg} > cc_m1) ? cc_m1 : {1'b0, lim_reg};

    // Request fields and latched item.
    logic s_accept;
    logic [CPU_IDX_W-1:0] s_cpu;
    logic [7:0]           s_cpu_ext;

    assign s_accept  = s_tvalid && s_tready;
    assign s_cpu     = s_tdata[5:0];
    assign s_cpu_ext = {2'b00, s_cpu};

    logic                 act_reg;
    logic [CPU_IDX_W-1:0] cpu_reg;
    logic [KIND_W-1:0]    kind_reg;
    logic [TIME_W-1:0]    time_reg;
    logic [COUNT_W-1:0]   cnt_reg;
    logic                 online_reg;
    logic [OFFL_W-1:0]    offl_reg;
    logic                 ok_reg;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            act_reg    <= s_tuser[0];
            kind_reg   <= s_tuser[2:1];
            cpu_reg    <= s_cpu;
            time_reg   <= s_tdata[37:6];
            cnt_reg    <= s_tdata[53:38];
            online_reg <= s_tdata[54];
            offl_reg   <= s_tdata[61:55];
            ok_reg     <= s_tdata[62];
        end
    end

    logic [7:0]        cpu_ext;
    logic [CPU_AW-1:0] cpu_a;

    assign cpu_ext = {2'b00, cpu_reg};
    assign cpu_a   = cpu_ext[CPU_AW-1:0];

    // Sequencer state.
    logic [2:0]        state_reg, state_next;
    logic [HEAD_W-1:0] head_reg, head_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic              uflag_reg, uflag_next;
    logic [TIME_W-1:0] tail_time_reg, tail_time_next;
    logic              tail_pend_reg, tail_pend_next;
    logic [OUTC_W-1:0] outc_reg, outc_next;
    logic              wb_reg, wb_next;

    logic              m_valid_reg, m_valid_next;
    logic [OUTC_W-1:0] m_outc_reg;
    logic [CPU_IDX_W-1:0] m_cpu_reg;
    logic [SUM_W-1:0]  m_sum_reg;

    assign s_tready  = (state_reg == ST_IDLE);

    // Table, ring and shared sum unit.
    logic [HEAD_W-1:0] t_head;
    logic [FILL_W-1:0] t_fill;
    logic [SUM_W-1:0]  t_sum;
    logic              t_uflag;
    logic              tbl_we, tbl_clr;

    logic              ring_we, ring_re;
    logic [HEAD_W-1:0] ring_wr_slot, ring_rd_slot;
    ring_entry_t       ring_wdata, ring_rdata;

    logic [SUM_W-1:0]  su_in, su_out;
    sum_op_t           su_op;

    cewi_cpu_table #(
        .CPU_AW (CPU_AW),
        .HEAD_W (HEAD_W),
        .FILL_W (FILL_W)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (s_accept),
        .rd_addr  (s_cpu_ext[CPU_AW-1:0]),
        .wr_en    (tbl_we),
        .wr_addr  (cpu_a),
        .wr_head  (head_reg),
        .wr_fill  (fill_reg),
        .wr_sum   (sum_reg),
        .wr_uflag (uflag_reg),
        .clr_en   (tbl_clr),
        .clr_addr (cpu_a),
        .rd_head  (t_head),
        .rd_fill  (t_fill),
        .rd_sum   (t_sum),
        .rd_uflag (t_uflag)
    );

    cewi_ring_mem #(
        .ADDR_W (RING_AW)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ring_we),
        .wr_addr ({cpu_a, ring_wr_slot}),
        .wr_data (ring_wdata),
        .rd_en   (ring_re),
        .rd_addr ({cpu_a, ring_rd_slot}),
        .rd_data (ring_rdata)
    );

    cewi_sum_unit u_sum (
        .sum_in  (su_in),
        .op      (su_op),
        .sum_out (su_out)
    );

    logic              bad_cpu;
    logic              limit_hit;
    logic              push;
    logic [HEAD_W-1:0] head_inc;
    logic [TIME_W-1:0] span;
    logic              evict;
    logic [SUM_W-1:0]  sum_final;
    logic              out_load;

    assign bad_cpu   = ({1'b0, cpu_reg} >= cc_reg) || ({3'b000, cpu_reg} >= NCPU_9);
    assign limit_hit = (offl_reg >= lim_eff);
    assign push      = (kind_reg == KIND_CE) && (t_fill < DEPTH_F);
    assign head_inc  = wrap_slot(WRAP_W'(head_reg) + WRAP_W'(1));
    assign span      = tail_time_reg - ring_rdata.ts;
    assign evict     = (fill_reg != '0) && (span > TIME_W'(win_cap));
    assign sum_final = evict ? su_out : sum_reg;
    assign out_load  = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    assign ring_wdata.ts  = time_reg;
    assign ring_wdata.cnt = cnt_reg;

    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        sum_next       = sum_reg;
        uflag_next     = uflag_reg;
        tail_time_next = tail_time_reg;
        tail_pend_next = tail_pend_reg;
        outc_next      = outc_reg;
        wb_next        = wb_reg;
        tbl_we         = 1'b0;
        tbl_clr        = 1'b0;
        ring_we        = 1'b0;
        ring_re        = 1'b0;
        ring_wr_slot   = wrap_slot(WRAP_W'(t_head) + WRAP_W'(t_fill));
        ring_rd_slot   = head_reg;
        su_in          = t_sum;
        su_op.sub      = 1'b0;
        su_op.operand  = cnt_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                head_next      = t_head;
                fill_next      = t_fill;
                sum_next       = t_sum;
                uflag_next     = t_uflag;
                wb_next        = 1'b0;
                tail_pend_next = 1'b0;
                state_next     = ST_DONE;
                if (!en_reg) begin
                    outc_next = OUT_DISABLED;
                    sum_next  = '0;
                end else if (bad_cpu) begin
                    outc_next = OUT_BAD_CPU;
                    sum_next  = '0;
                end else if (act_reg == ACT_REPORT) begin
                    if (ok_reg) begin
                        tbl_clr   = 1'b1;
                        outc_next = OUT_CLEARED;
                        sum_next  = '0;
                    end else begin
                        outc_next = OUT_NONE;
                    end
                end else if (!online_reg) begin
                    outc_next = OUT_NOT_ONLINE;
                end else begin
                    wb_next = 1'b1;
                    if (push) begin
                        ring_we        = 1'b1;
                        fill_next      = t_fill + 1'b1;
                        sum_next       = su_out;
                        tail_time_next = time_reg;
                    end
                    if (kind_reg == KIND_UE) begin
                        uflag_next = 1'b1;
                    end
                    if (limit_hit) begin
                        outc_next = OUT_LIMIT;
                    end else if (kind_reg == KIND_CE) begin
                        // A dropped push into a full ring still needs the newest time.
                        tail_pend_next = !push;
                        state_next     = push ? ST_HEAD : ST_TAIL;
                    end else if (kind_reg == KIND_UE) begin
                        outc_next = OUT_REQUEST;
                    end else begin
                        outc_next = OUT_NONE;
                    end
                end
            end
            ST_TAIL: begin
                ring_re      = 1'b1;
                ring_rd_slot = wrap_slot(WRAP_W'(head_reg) + WRAP_W'(fill_reg) - WRAP_W'(1));
                state_next   = ST_HEAD;
            end
            ST_HEAD: begin
                if (tail_pend_reg) begin
                    tail_time_next = ring_rdata.ts;
                end
                ring_re      = 1'b1;
                ring_rd_slot = head_reg;
                state_next   = ST_CHECK;
            end
            ST_CHECK: begin
                // Each cycle judges the entry read last cycle and fetches the next one.
                su_in         = sum_reg;
                su_op.sub     = 1'b1;
                su_op.operand = ring_rdata.cnt;
                ring_rd_slot  = head_inc;
                if (evict) begin
                    sum_next  = su_out;
                    head_next = head_inc;
                    fill_next = fill_reg - 1'b1;
                end
                if (evict && (fill_reg != FILL_W'(1))) begin
                    ring_re = 1'b1;
                end else begin
                    outc_next  = (sum_final >= SUM_W'(thr_cap)) ? OUT_REQUEST : OUT_NONE;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    tbl_we     = wb_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            tail_pend_reg <= 1'b0;
            wb_reg        <= 1'b0;
        end else begin
            state_reg     <= state_next;
            tail_pend_reg <= tail_pend_next;
            wb_reg        <= wb_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg      <= head_next;
        fill_reg      <= fill_next;
        sum_reg       <= sum_next;
        uflag_reg     <= uflag_next;
        tail_time_reg <= tail_time_next;
        outc_reg      <= outc_next;
    end

    // Output register.
    assign m_valid_next = out_load ? 1'b1 : (m_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_outc_reg <= outc_reg;
            m_cpu_reg  <= cpu_reg;
            m_sum_reg  <= sum_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_outc_reg;
    assign m_tdata  = {6'b000000, m_sum_reg, m_cpu_reg};

    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == ST_LOAD)
        else $error("accepted request did not start the lookup");

    a_check_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CHECK |-> fill_reg != '0)
        else $error("eviction loop running on an empty ring");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CHECK || state_reg == ST_HEAD |-> fill_reg <= DEPTH_F)
        else $error("ring fill exceeds ring depth");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == ST_DONE)
        else $error("result appeared without a finished request");

    a_zero_sum_codes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == OUT_DISABLED || m_tuser == OUT_BAD_CPU
                     || m_tuser == OUT_CLEARED) |-> m_tdata[25:6] == '0)
        else $error("rejected or cleared request reports a nonzero sum");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import cewi_pkg::*;

    localparam int N_CPUS      = 64;
    localparam int RING_SLOTS  = 16;
    localparam int QUIET_LIMIT = 5000;
    localparam int N_PHASES    = 9;

    // Error kinds that the block records nowhere.
    localparam logic [KIND_W-1:0] KIND_OTHER = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    typedef struct packed {
        logic                 action;
        logic [CPU_IDX_W-1:0] cpu;
        logic [KIND_W-1:0]    kind;
        logic [TIME_W-1:0]    ts;
        logic [COUNT_W-1:0]   cnt;
        logic                 online;
        logic [OFFL_W-1:0]    offl;
        logic                 ok;
    } request_t;

    typedef struct packed {
        logic [OUTC_W-1:0]    outcome;
        logic [CPU_IDX_W-1:0] cpu;
        logic [SUM_W-1:0]     total;
    } verdict_t;

    class window_scoreboard;
        logic               en;
        logic [CC_W-1:0]    cpus;
        logic [THR_W-1:0]   thr;
        logic [LIM_W-1:0]   lim;
        logic [WIN_W-1:0]   win;
        logic [TIME_W-1:0]  ring_ts  [N_CPUS][RING_SLOTS];
        logic [COUNT_W-1:0] ring_cnt [N_CPUS][RING_SLOTS];
        int unsigned        head     [N_CPUS];
        int unsigned        fill     [N_CPUS];
        logic [SUM_W-1:0]   ce_total [N_CPUS];
        logic               ue_seen  [N_CPUS];
        verdict_t           expected_q [$];
        int                 errors;

        function new();
            en     = 1'b0;
            cpus   = CC_RESET;
            thr    = THR_RESET;
            lim    = '0;
            win    = WIN_RESET;
            errors = 0;
            for (int c = 0; c < N_CPUS; c++) forget_cpu(c);
        endfunction

        function void forget_cpu(int unsigned c);
            head[c]     = 0;
            fill[c]     = 0;
            ce_total[c] = '0;
            ue_seen[c]  = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ENABLE:    en   = data[0];
                CFG_CPU_COUNT: cpus = data[CC_W-1:0];
                CFG_THRESHOLD: thr  = data[THR_W-1:0];
                CFG_OFF_LIMIT: lim  = data[LIM_W-1:0];
                CFG_WINDOW:    win  = data[WIN_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_request(request_t r);
            verdict_t          v;
            int unsigned       c;
            int unsigned       slot;
            int unsigned       h;
            int unsigned       t;
            int unsigned       sum_next;
            int unsigned       lim_eff;
            int unsigned       cc_m1;
            int unsigned       thr_eff;
            logic [WIN_W-1:0]  win_eff;
            logic [TIME_W-1:0] span;

            c         = r.cpu;
            v.outcome = OUT_NONE;
            v.cpu     = r.cpu;
            v.total   = '0;
            if (!en) begin
                v.outcome = OUT_DISABLED;
            end else if (c >= cpus || c >= N_CPUS) begin
                v.outcome = OUT_BAD_CPU;
            end else if (r.action == ACT_REPORT) begin
                if (r.ok) begin
                    forget_cpu(c);
                    v.outcome = OUT_CLEARED;
                end else begin
                    v.total = ce_total[c];
                end
            end else if (!r.online) begin
                v.outcome = OUT_NOT_ONLINE;
                v.total   = ce_total[c];
            end else begin
                // A corrected event into a full ring is dropped but still evaluated.
                if (r.kind == KIND_CE && fill[c] < RING_SLOTS) begin
                    slot              = (head[c] + fill[c]) % RING_SLOTS;
                    ring_ts[c][slot]  = r.ts;
                    ring_cnt[c][slot] = r.cnt;
                    fill[c]++;
                    sum_next    = ce_total[c] + r.cnt;
                    ce_total[c] = (sum_next > SUM_MAX) ? SUM_MAX : sum_next[SUM_W-1:0];
                end else if (r.kind == KIND_UE) begin
                    ue_seen[c] = 1'b1;
                end
                lim_eff = lim;
                cc_m1   = cpus;
                cc_m1   = cc_m1 - 1;
                if (lim_eff > cc_m1) lim_eff = cc_m1;
                if (r.offl >= lim_eff) begin
                    v.outcome = OUT_LIMIT;
                end else if (r.kind == KIND_CE) begin
                    win_eff = (win > WINDOW_CAP) ? WINDOW_CAP : win;
                    thr_eff = (thr > THRESHOLD_CAP) ? THRESHOLD_CAP : thr;
                    while (fill[c] > 0) begin
                        h    = head[c];
                        t    = (head[c] + fill[c] - 1) % RING_SLOTS;
                        span = ring_ts[c][t] - ring_ts[c][h];
                        if (span <= win_eff) break;
                        ce_total[c] = (ce_total[c] > ring_cnt[c][h]) ?
                                      ce_total[c] - ring_cnt[c][h] : '0;
                        head[c] = (h + 1) % RING_SLOTS;
                        fill[c]--;
                    end
                    if (ce_total[c] >= thr_eff) v.outcome = OUT_REQUEST;
                end else if (r.kind == KIND_UE) begin
                    v.outcome = ue_seen[c] ? OUT_REQUEST : OUT_NONE;
                end
                v.total = ce_total[c];
            end
            expected_q.push_back(v);
        endfunction

        function void check_result(logic [OUTC_W-1:0] outc, logic [31:0] data);
            verdict_t want;
            verdict_t got;

            got.outcome = outc;
            got.cpu     = data[CPU_IDX_W-1:0];
            got.total   = data[CPU_IDX_W +: SUM_W];
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result outcome %0d cpu %0d sum %0d",
                             $realtime, got.outcome, got.cpu, got.total);
            end else begin
                want = expected_q.pop_front();
                if (got.outcome !== want.outcome || got.cpu !== want.cpu ||
                    got.total !== want.total) begin
                    errors++;
                    if (errors <= 10) begin
                        $write("%0t: mismatch expected outcome %0d cpu %0d sum %0d, ",
                               $realtime, want.outcome, want.cpu, want.total);
                        $display("got outcome %0d cpu %0d sum %0d",
                                 got.outcome, got.cpu, got.total);
                    end
                end
            end
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [63:0]           s_tdata   = '0;
    logic [2:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [31:0]           m_tdata;
    logic [OUTC_W-1:0]     m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    window_scoreboard sb;

    int unsigned now_ts    = 0;
    int          burst_left = 0;
    int unsigned cur_cpus  = 64;
    int unsigned cur_thr   = 18;
    int unsigned cur_lim   = 0;
    int unsigned cur_win   = 86400;
    int          quiet_cycles = 0;
    int          stall_left   = 0;
    int          mode_left    = 0;
    bit          choppy       = 1'b0;

    int plan_en    [N_PHASES] = '{1, 1, 1, 1, 0, 1, 1, 1, 1};
    int plan_cpus  [N_PHASES] = '{64, 8, 127, 1, 64, 0, 16, 64, 64};
    int plan_thr   [N_PHASES] = '{18, 0, 16383, 100, 18, 50, 10000, 500, 9999};
    int plan_lim   [N_PHASES] = '{63, 8, 63, 5, 63, 10, 0, 40, 63};
    int plan_win   [N_PHASES] = '{86400, 0, 4194303, 1000, 86400, 500, 2592000, 3600,
                                  2592000};
    int plan_items [N_PHASES] = '{180, 110, 140, 60, 25, 25, 80, 180, 130};

    cpu_error_window_isolator #(
        .NUM_CPUS   (N_CPUS),
        .RING_DEPTH (RING_SLOTS)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // The receiver alternates between steady stretches and stretches of random stalls.
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            choppy    = ($urandom_range(0, 2) != 0);
            mode_left = $urandom_range(50, 400);
        end
        mode_left--;
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (choppy && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(0, 30);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic push_request(input request_t r);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, r.ok, r.offl, r.online, r.cnt, r.ts, r.cpu};
        s_tuser  <= {r.kind, r.action};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(r);
        burst_left--;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, value[CFG_DATA_W-1:0]);
    endtask

    task automatic program_regs(input int unsigned en, input int unsigned cpus,
                                input int unsigned thr, input int unsigned lim,
                                input int unsigned win);
        write_reg(CFG_ENABLE, en);
        write_reg(CFG_CPU_COUNT, cpus);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_OFF_LIMIT, lim);
        write_reg(CFG_WINDOW, win);
        cfg_valid <= 1'b0;
        cur_cpus = cpus;
        cur_thr  = thr;
        cur_lim  = lim;
        cur_win  = win;
    endtask

    // Registers change only once every outstanding request has produced its result.
    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    function automatic request_t scripted(logic action, int unsigned cpu,
                                          logic [KIND_W-1:0] kind, int unsigned dt,
                                          int unsigned cnt, logic online,
                                          int unsigned offl, logic ok);
        request_t r;
        now_ts   = now_ts + dt;
        r.action = action;
        r.cpu    = cpu;
        r.kind   = kind;
        r.ts     = now_ts;
        r.cnt    = cnt;
        r.online = online;
        r.offl   = offl;
        r.ok     = ok;
        return r;
    endfunction

    // Mostly corrected events on a few busy CPUs so that rings fill and windows slide.
    function automatic request_t next_request();
        request_t    r;
        int unsigned lim_eff;
        int unsigned win_eff;
        int unsigned thr_eff;
        int unsigned hot_hi;
        int unsigned pick;
        int unsigned dt;

        lim_eff = cur_lim;
        if (cur_cpus != 0 && lim_eff > cur_cpus - 1) lim_eff = cur_cpus - 1;
        win_eff = (cur_win > WINDOW_CAP) ? WINDOW_CAP : cur_win;
        thr_eff = (cur_thr > THRESHOLD_CAP) ? THRESHOLD_CAP : cur_thr;
        hot_hi  = (cur_cpus == 0) ? 0 : ((cur_cpus > 4) ? 3 : cur_cpus - 1);

        r.action = ACT_EVENT;
        r.cpu    = $urandom_range(0, hot_hi);
        r.kind   = KIND_CE;
        r.online = 1'b1;
        r.offl   = (lim_eff == 0) ? $urandom_range(0, 64) : $urandom_range(0, lim_eff - 1);
        r.ok     = $urandom_range(0, 1);
        pick     = $urandom_range(0, 39);
        if (pick == 0)
            r.cnt = '1;
        else if (pick < 5)
            r.cnt = $urandom;
        else
            r.cnt = $urandom_range(0, thr_eff / 6 + 2);

        pick = $urandom_range(0, 99);
        if (pick >= 70 && pick < 78) begin
            r.kind = KIND_UE;
        end else if (pick >= 78 && pick < 85) begin
            r.action = ACT_REPORT;
            r.ok     = ($urandom_range(0, 2) == 0);
            r.online = $urandom_range(0, 1);
            r.offl   = $urandom_range(0, 64);
        end else if (pick >= 85 && pick < 90) begin
            r.kind = $urandom_range(KIND_OTHER, KIND_SPARE);
        end else if (pick >= 90 && pick < 94) begin
            r.online = 1'b0;
        end else if (pick >= 94 && pick < 97) begin
            r.cpu = (cur_cpus == 0 || cur_cpus >= 64) ? $urandom_range(0, 63)
                                                      : $urandom_range(cur_cpus, 63);
        end else if (pick >= 97) begin
            r.action = $urandom_range(0, 1);
            r.cpu    = $urandom_range(0, 63);
            r.kind   = $urandom_range(0, 3);
            r.online = $urandom_range(0, 1);
            r.offl   = $urandom_range(0, 64);
        end

        pick = $urandom_range(0, 99);
        if (pick < 60)
            dt = $urandom_range(0, win_eff / 8 + 1);
        else if (pick < 85)
            dt = $urandom_range(0, win_eff + 1);
        else if (pick < 97)
            dt = win_eff + $urandom_range(1, win_eff / 2 + 10);
        else
            dt = $urandom >> 1;
        now_ts = now_ts + dt;
        r.ts   = now_ts;
        return r;
    endfunction

    initial begin
        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Out of reset the block is disabled.
        push_request(scripted(ACT_EVENT, 0, KIND_CE, 0, 5, 1'b1, 0, 1'b0));
        push_request(scripted(ACT_REPORT, 5, KIND_CE, 0, 0, 1'b1, 0, 1'b1));
        settle();
        program_regs(1, 4, 20, 3, 100);

        // Times start just below the wrap point so the window spans it.
        now_ts = 32'hFFFF_FFC0;
        push_request(scripted(ACT_EVENT, 0, KIND_CE, 0, 5, 1'b1, 0, 1'b0));
        push_request(scripted(ACT_EVENT, 0, KIND_CE, 10, 15, 1'b1, 2, 1'b0));
        push_request(scripted(ACT_REPORT, 0, KIND_CE, 0, 0, 1'b0, 64, 1'b0));
        push_request(scripted(ACT_REPORT, 0, KIND_UE, 0, 65535, 1'b1, 0, 1'b1));
        push_request(scripted(ACT_EVENT, 1, KIND_UE, 1, 0, 1'b1, 0, 1'b0));
        push_request(scripted(ACT_EVENT, 2, KIND_OTHER, 1, 65535, 1'b1, 0, 1'b0));
        push_request(scripted(ACT_EVENT, 2, KIND_SPARE, 0, 7, 1'b1, 1, 1'b0));
        push_request(scripted(ACT_EVENT, 1, KIND_CE, 0, 3, 1'b0, 0, 1'b0));
        push_request(scripted(ACT_EVENT, 4, KIND_CE, 0, 3, 1'b1, 0, 1'b0));
        push_request(scripted(ACT_REPORT, 63, KIND_CE, 0, 0, 1'b1, 0, 1'b1));
        push_request(scripted(ACT_EVENT, 2, KIND_CE, 5, 7, 1'b1, 3, 1'b0));
        push_request(scripted(ACT_EVENT, 2, KIND_UE, 0, 0, 1'b1, 64, 1'b0));
        push_request(scripted(ACT_EVENT, 2, KIND_CE, 30, 65535, 1'b1, 0, 1'b0));
        push_request(scripted(ACT_EVENT, 2, KIND_CE, 200, 1, 1'b1, 0, 1'b0));
        push_request(scripted(ACT_EVENT, 3, KIND_CE, 100, 4, 1'b1, 0, 1'b0));

        for (int p = 0; p < N_PHASES; p++) begin
            settle();
            program_regs(plan_en[p], plan_cpus[p], plan_thr[p], plan_lim[p], plan_win[p]);
            if ($urandom_range(0, 2) == 0) now_ts = now_ts + $urandom;
            for (int i = 0; i < plan_items[p]; i++) push_request(next_request());
        end

        settle();
        repeat (40) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/cewi_pkg.sv
rtl/cewi_ring_mem.sv
rtl/cewi_cpu_table.sv
rtl/cewi_sum_unit.sv
rtl/cpu_error_window_isolator.sv
tb/testbench.sv
